/* hdl/mccp_pkg.sv */
// Package for the min-cost conversion path block: sizes, codes and the
// command and status structs between the controller and the datapath. No dependencies.
`default_nettype none
package mccp_pkg;
    localparam int TYPE_SLOTS = 32;
    localparam int EDGE_SLOTS = 256;
    localparam int MAX_PATH   = 31;
    localparam int EIDX_W     = $clog2(EDGE_SLOTS);
    localparam int ECNT_W     = $clog2(EDGE_SLOTS + 1);
    localparam int DIST_W     = 22;
    localparam logic [DIST_W-1:0] DIST_INF = '1;

    localparam logic [1:0] FN_LOAD  = 2'd0;
    localparam logic [1:0] FN_FIND  = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;

    localparam logic [1:0] ST_EDGE   = 2'd0;
    localparam logic [1:0] ST_SAME   = 2'd1;
    localparam logic [1:0] ST_NOPATH = 2'd2;
    localparam logic [1:0] ST_BAD    = 2'd3;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       capture;
        logic       init;
        logic       scan_start;
        logic       scan_step;
        logic       settle;
        logic       relax_step;
        logic       check;
        logic       walk_init;
        logic       walk_read;
        logic       walk_data;
        logic       emit_init;
        logic       emit_read;
        logic       emit_load;
        logic       stat_load;
        logic [1:0] stat_code;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic same;
        logic scan_last;
        logic found;
        logic relax_done;
        logic unreach;
        logic walk_done;
        logic pop_empty;
        logic out_full;
    } t_sts;
endpackage
`default_nettype wire

/* hdl/min_cost_conversion_path_core.sv */
// Top level of the min-cost conversion path block.
// Depends on mccp_pkg, mccp_ctrl and mccp_datapath.
//
//  channel   direction  handshake          payload
//  request   in         i_valid/o_ready    i_func i_src_type i_dst_type i_edge_cost
//  result    out        o_valid/i_ready    o_status o_edge_id o_from_type o_to_type o_last
//  config    in         i_cfg_we           i_cfg_data (types_in_use)
//
// Load and clear requests complete in the idle state on acceptance and may follow back to back.
// After acceptance a path query runs R settled rounds, each scanning n types and relaxing
// E stored edges one per cycle through the edge store read port, then one closing scan,
// then walks back over the P path edges and emits them, waiting while the output is full.
// A status answer also waits for a free output register.
// Reset (synchronous, active low) empties the edge store and sets 32 types in use.
// A stalled result holds in the output register; after a query's last result the next request is accepted meanwhile.
`default_nettype none
module min_cost_conversion_path_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [4:0]  i_src_type,
    input  wire logic [4:0]  i_dst_type,
    input  wire logic [15:0] i_edge_cost,
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_edge_id,
    output logic [4:0]       o_from_type,
    output logic [4:0]       o_to_type,
    output logic             o_last
);
    mccp_pkg::t_cmd cmd;
    mccp_pkg::t_sts sts;

    // sequence every request; datapath follows its commands
    mccp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mccp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_src_type  (i_src_type),
        .i_dst_type  (i_dst_type),
        .i_edge_cost (i_edge_cost),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_edge_id   (o_edge_id),
        .o_from_type (o_from_type),
        .o_to_type   (o_to_type),
        .o_last      (o_last)
    );
endmodule
`default_nettype wire

/* hdl/mccp_datapath.sv */
// Datapath: edge store, distance/settled/via arrays, path stack and result register.
// Depends on mccp_pkg; driven by mccp_ctrl commands.
`default_nettype none
module mccp_datapath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mccp_pkg::t_cmd  i_cmd,
    output mccp_pkg::t_sts       o_sts,
    input  wire logic [4:0]      i_src_type,
    input  wire logic [4:0]      i_dst_type,
    input  wire logic [15:0]     i_edge_cost,
    input  wire logic            i_cfg_we,
    input  wire logic [5:0]      i_cfg_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [1:0]           o_status,
    output logic [7:0]           o_edge_id,
    output logic [4:0]           o_from_type,
    output logic [4:0]           o_to_type,
    output logic                 o_last
);
    logic [25:0] r_mem [mccp_pkg::EDGE_SLOTS];
    logic [25:0] r_rdata;
    logic [mccp_pkg::EIDX_W-1:0] mem_addr;
    logic [mccp_pkg::ECNT_W-1:0] r_cnt, r_k;
    logic [mccp_pkg::EIDX_W-1:0] r_kp;
    logic r_pv;

    logic [mccp_pkg::DIST_W-1:0] r_dist [mccp_pkg::TYPE_SLOTS];
    logic [mccp_pkg::TYPE_SLOTS-1:0] r_settled;
    logic [mccp_pkg::EIDX_W-1:0] r_via [mccp_pkg::TYPE_SLOTS];
    logic [mccp_pkg::EIDX_W-1:0] r_stack [mccp_pkg::TYPE_SLOTS];

    logic [5:0] r_types;
    logic [5:0] n_eff;
    logic [4:0] r_src, r_dst, r_i, r_u, r_cur;
    logic [mccp_pkg::DIST_W-1:0] r_best;
    logic r_found;
    logic [5:0] r_depth, r_pop;
    logic [4:0] pop_idx;

    logic [4:0] d_addr, e_src, e_dst;
    logic [15:0] e_cost;
    logic [mccp_pkg::DIST_W-1:0] rd_dist;
    logic rd_settled;
    logic [mccp_pkg::DIST_W:0] sum;
    logic relax_hit;

    logic r_ovalid;
    logic [1:0] r_ostat;
    logic [7:0] r_oid;
    logic [4:0] r_ofrom, r_oto;
    logic r_olast;

    always_comb begin
        if (r_types == 6'd0) begin
            n_eff = 6'd1;
        end else if (r_types > 6'(mccp_pkg::TYPE_SLOTS)) begin
            n_eff = 6'(mccp_pkg::TYPE_SLOTS);
        end else begin
            n_eff = r_types;
        end
    end

    assign e_src   = r_rdata[4:0];
    assign e_dst   = r_rdata[9:5];
    assign e_cost  = r_rdata[25:10];
    assign pop_idx = 5'(r_pop - 6'd1);

    always_comb begin
        priority if (i_cmd.relax_step) begin
            d_addr = e_dst;
        end else if (i_cmd.check) begin
            d_addr = r_dst;
        end else begin
            d_addr = r_i;
        end
    end
    assign rd_dist    = r_dist[d_addr];
    assign rd_settled = r_settled[d_addr];
    assign sum        = {1'b0, r_best} + {7'd0, e_cost};
    assign relax_hit  = r_pv && (e_src == r_u) && ({1'b0, e_dst} < n_eff) && !rd_settled
                        && (sum < {1'b0, rd_dist});

    always_comb begin
        priority if (i_cmd.relax_step) begin
            mem_addr = r_k[mccp_pkg::EIDX_W-1:0];
        end else if (i_cmd.walk_read) begin
            mem_addr = r_via[r_cur];
        end else begin
            mem_addr = r_stack[pop_idx];
        end
    end

    // edge store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_cnt < mccp_pkg::ECNT_W'(mccp_pkg::EDGE_SLOTS)) begin
            r_mem[r_cnt[mccp_pkg::EIDX_W-1:0]] <= {i_edge_cost, i_dst_type, i_src_type};
        end
        r_rdata <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_types   <= 6'd32;
            r_settled <= '0;
            r_pv      <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_types <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_cnt <= '0;
            end else if (i_cmd.load && r_cnt < mccp_pkg::ECNT_W'(mccp_pkg::EDGE_SLOTS)) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.init) begin
                r_settled <= '0;
            end else if (i_cmd.settle) begin
                r_settled[r_u] <= 1'b1;
            end
            if (i_cmd.settle) begin
                r_pv <= 1'b0;
            end else if (i_cmd.relax_step) begin
                r_pv <= (r_k < r_cnt);
            end
            if (i_cmd.emit_load || i_cmd.stat_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_src <= i_src_type;
            r_dst <= i_dst_type;
        end
        if (i_cmd.init) begin
            for (int j = 0; j < mccp_pkg::TYPE_SLOTS; j++) begin
                r_dist[j] <= mccp_pkg::DIST_INF;
                r_via[j]  <= '0;
            end
            r_dist[r_src] <= '0;
        end else if (relax_hit && i_cmd.relax_step) begin
            r_dist[e_dst] <= sum[mccp_pkg::DIST_W-1:0];
            r_via[e_dst]  <= r_kp;
        end
        if (i_cmd.init || i_cmd.scan_start) begin
            r_i     <= '0;
            r_best  <= mccp_pkg::DIST_INF;
            r_found <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_i <= r_i + 1'b1;
            if (!rd_settled && rd_dist < r_best) begin
                r_best  <= rd_dist;
                r_u     <= r_i;
                r_found <= 1'b1;
            end
        end
        if (i_cmd.settle) begin
            r_k <= '0;
        end else if (i_cmd.relax_step && r_k < r_cnt) begin
            r_k  <= r_k + 1'b1;
            r_kp <= r_k[mccp_pkg::EIDX_W-1:0];
        end
        if (i_cmd.walk_init) begin
            r_cur   <= r_dst;
            r_depth <= '0;
        end else if (i_cmd.walk_read) begin
            r_stack[r_depth[4:0]] <= r_via[r_cur];
            r_depth <= r_depth + 1'b1;
        end else if (i_cmd.walk_data) begin
            r_cur <= e_src;
        end
        if (i_cmd.emit_init) begin
            r_pop <= r_depth;
        end else if (i_cmd.emit_load) begin
            r_pop <= r_pop - 1'b1;
        end
        if (i_cmd.emit_load) begin
            r_ostat <= mccp_pkg::ST_EDGE;
            r_oid   <= 8'(r_stack[pop_idx]);
            r_ofrom <= e_src;
            r_oto   <= e_dst;
            r_olast <= (r_pop == 6'd1);
        end else if (i_cmd.stat_load) begin
            r_ostat <= i_cmd.stat_code;
            r_oid   <= '0;
            r_ofrom <= r_src;
            r_oto   <= r_dst;
            r_olast <= 1'b1;
        end
    end

    always_comb begin
        o_sts.bad        = ({1'b0, r_src} >= n_eff) || ({1'b0, r_dst} >= n_eff);
        o_sts.same       = (r_src == r_dst);
        o_sts.scan_last  = ({1'b0, r_i} == n_eff - 6'd1);
        o_sts.found      = r_found;
        o_sts.relax_done = (r_k >= r_cnt) && !r_pv;
        o_sts.unreach    = (rd_dist == mccp_pkg::DIST_INF);
        o_sts.walk_done  = (r_cur == r_src) || (r_depth == 6'(mccp_pkg::MAX_PATH));
        o_sts.pop_empty  = (r_pop == 6'd0);
        o_sts.out_full   = r_ovalid;
    end

    assign o_valid     = r_ovalid;
    assign o_status    = r_ostat;
    assign o_edge_id   = r_oid;
    assign o_from_type = r_ofrom;
    assign o_to_type   = r_oto;
    assign o_last      = r_olast;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mccp_pkg::ECNT_W'(mccp_pkg::EDGE_SLOTS))
        else $error("edge count beyond store");
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_read |-> r_depth < 6'(mccp_pkg::MAX_PATH))
        else $error("path stack overrun");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_load || i_cmd.stat_load) |-> !r_ovalid)
        else $error("result register overwritten");
endmodule
`default_nettype wire

/* hdl/mccp_ctrl.sv */
// Controller state machine sequencing load, search, walk-back and emit.
// Depends on mccp_pkg; drives mccp_datapath through t_cmd.
`default_nettype none
module mccp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [1:0]     i_func,
    output logic                o_ready,
    input  wire mccp_pkg::t_sts i_sts,
    output mccp_pkg::t_cmd      o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_STAT, S_INIT, S_SCAN, S_CHOOSE, S_RELAX,
        S_FINISH, S_WALK, S_WALK_WAIT, S_EMIT, S_EMIT_WAIT
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_code, n_code;
    logic acc;

    assign o_ready = (r_state == S_IDLE);
    assign acc     = i_valid && o_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_code  = r_code;
        o_cmd.stat_code = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.load    = (i_func == mccp_pkg::FN_LOAD);
                    o_cmd.clear   = (i_func == mccp_pkg::FN_CLEAR);
                    o_cmd.capture = (i_func == mccp_pkg::FN_FIND);
                    if (i_func == mccp_pkg::FN_FIND) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                priority if (i_sts.bad) begin
                    n_code  = mccp_pkg::ST_BAD;
                    n_state = S_STAT;
                end else if (i_sts.same) begin
                    n_code  = mccp_pkg::ST_SAME;
                    n_state = S_STAT;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_STAT: begin
                if (!i_sts.out_full) begin
                    o_cmd.stat_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_CHOOSE;
                end
            end
            S_CHOOSE: begin
                if (i_sts.found) begin
                    o_cmd.settle = 1'b1;
                    n_state = S_RELAX;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_RELAX: begin
                if (i_sts.relax_done) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.relax_step = 1'b1;
                end
            end
            S_FINISH: begin
                o_cmd.check = 1'b1;
                if (i_sts.unreach) begin
                    n_code  = mccp_pkg::ST_NOPATH;
                    n_state = S_STAT;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    o_cmd.emit_init = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.walk_read = 1'b1;
                    n_state = S_WALK_WAIT;
                end
            end
            S_WALK_WAIT: begin
                o_cmd.walk_data = 1'b1;
                n_state = S_WALK;
            end
            S_EMIT: begin
                priority if (i_sts.pop_empty) begin
                    n_state = S_IDLE;
                end else if (!i_sts.out_full) begin
                    o_cmd.emit_read = 1'b1;
                    n_state = S_EMIT_WAIT;
                end
            end
            S_EMIT_WAIT: begin
                o_cmd.emit_load = 1'b1;
                n_state = S_EMIT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= mccp_pkg::ST_EDGE;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    a_emit_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_read |=> r_state == S_EMIT_WAIT)
        else $error("emit read not followed by load");
    a_relax_after_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.settle |=> r_state == S_RELAX)
        else $error("settle without relax pass");
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("request taken while busy");
endmodule
`default_nettype wire

/* verif/testbench.sv */
// Self-checking bench for min_cost_conversion_path_core: a predictor mirrors the
// edge store and the path search, a small class queues and checks path results.
// Depends on mccp_pkg and the core.
`default_nettype none
module testbench;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] edge_id;
        logic [4:0] from_type;
        logic [4:0] to_type;
        logic       last;
    } t_path_res;

    // Path result store: note predicted results, check arriving ones in order
    class path_board;
        t_path_res pending[$];
        int        errors;

        function void note_results(t_path_res r[$]);
            foreach (r[i]) pending.push_back(r[i]);
        endfunction

        function void check_result(t_path_res got);
            t_path_res want;
            if (pending.size() == 0) begin
                $error("result with no expectation: status %0d", got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.edge_id != want.edge_id) begin
                $error("edge_id expected %0d actual %0d", want.edge_id, got.edge_id);
                errors++;
            end
            if (got.from_type != want.from_type) begin
                $error("from_type expected %0d actual %0d", want.from_type,
                       got.from_type);
                errors++;
            end
            if (got.to_type != want.to_type) begin
                $error("to_type expected %0d actual %0d", want.to_type, got.to_type);
                errors++;
            end
            if (got.last != want.last) begin
                $error("last expected %0d actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_func = mccp_pkg::FN_LOAD;
    logic [4:0]  i_src_type = 0;
    logic [4:0]  i_dst_type = 0;
    logic [15:0] i_edge_cost = 0;
    logic        i_cfg_we = 0;
    logic [5:0]  i_cfg_data = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [1:0]  o_status;
    logic [7:0]  o_edge_id;
    logic [4:0]  o_from_type;
    logic [4:0]  o_to_type;
    logic        o_last;

    min_cost_conversion_path_core i_dut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // Predictor state
    logic [4:0]  pr_src [mccp_pkg::EDGE_SLOTS];
    logic [4:0]  pr_dst [mccp_pkg::EDGE_SLOTS];
    logic [15:0] pr_cost[mccp_pkg::EDGE_SLOTS];
    int          pr_count;
    logic [5:0]  pr_types;

    path_board board;
    int  idle_pct = 22;
    bit  hold_off = 0;
    int  quiet = 0;

    // Dense search; updates the edge mirror for loads and clears, returns the results one request causes
    function automatic void predict_request(logic [1:0] fn, logic [4:0] s,
                                            logic [4:0] d, logic [15:0] c,
                                            ref t_path_res res[$]);
        int          n, u, v, round, cur, depth;
        logic [21:0] cost_to[mccp_pkg::TYPE_SLOTS];
        logic [21:0] best, sum;
        bit          done[mccp_pkg::TYPE_SLOTS];
        int          via[mccp_pkg::TYPE_SLOTS];
        int          stack[mccp_pkg::MAX_PATH + 1];
        bit          found;
        t_path_res   r;
        res = {};
        if (fn == mccp_pkg::FN_LOAD) begin
            if (pr_count < mccp_pkg::EDGE_SLOTS) begin
                pr_src[pr_count] = s;
                pr_dst[pr_count] = d;
                pr_cost[pr_count] = c;
                pr_count++;
            end
            return;
        end
        if (fn == mccp_pkg::FN_CLEAR) begin
            pr_count = 0;
            return;
        end
        if (fn != mccp_pkg::FN_FIND) return;
        n = int'(pr_types);
        if (n == 0) n = 1;
        if (n > mccp_pkg::TYPE_SLOTS) n = mccp_pkg::TYPE_SLOTS;
        r = '{status: mccp_pkg::ST_BAD, edge_id: 8'd0, from_type: s, to_type: d,
              last: 1'b1};
        if (s >= n || d >= n) begin
            res.push_back(r);
            return;
        end
        if (s == d) begin
            r.status = mccp_pkg::ST_SAME;
            res.push_back(r);
            return;
        end
        for (int i = 0; i < mccp_pkg::TYPE_SLOTS; i++) begin
            cost_to[i] = mccp_pkg::DIST_INF;
            done[i] = 0;
            via[i] = 0;
        end
        cost_to[s] = '0;
        for (round = 0; round < n; round++) begin
            best = mccp_pkg::DIST_INF;
            u = 0;
            found = 0;
            for (int i = 0; i < n; i++)
                if (!done[i] && cost_to[i] < best) begin
                    best = cost_to[i];
                    u = i;
                    found = 1;
                end
            if (!found) break;
            done[u] = 1;
            for (int k = 0; k < pr_count; k++) begin
                v = int'(pr_dst[k]);
                if (pr_src[k] != u || v >= n || done[v]) continue;
                sum = best + 22'(pr_cost[k]);
                if (sum < cost_to[v]) begin
                    cost_to[v] = sum;
                    via[v] = k;
                end
            end
        end
        if (cost_to[d] == mccp_pkg::DIST_INF) begin
            r.status = mccp_pkg::ST_NOPATH;
            res.push_back(r);
            return;
        end
        depth = 0;
        cur = int'(d);
        while (cur != s && depth < mccp_pkg::MAX_PATH) begin
            stack[depth++] = via[cur];
            cur = int'(pr_src[via[cur]]);
        end
        for (int i = 0; i < depth; i++) begin
            int k;
            k = stack[depth - 1 - i];
            r = '{status: mccp_pkg::ST_EDGE, edge_id: k[7:0], from_type: pr_src[k],
                  to_type: pr_dst[k], last: (i + 1 == depth)};
            res.push_back(r);
        end
    endfunction

    // Offer one request, hold it until accepted, then predict its results
    task automatic send_request(logic [1:0] fn, logic [4:0] s, logic [4:0] d,
                                logic [15:0] c);
        t_path_res res[$];
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        i_func = fn;
        i_src_type = s;
        i_dst_type = d;
        i_edge_cost = c;
        i_valid = 1;
        do @(posedge i_clk); while (!o_ready);
        predict_request(fn, s, d, c, res);
        board.note_results(res);
        @(negedge i_clk);
        i_valid = 0;
    endtask

    // Wait until every expected result is back and the block has settled
    task automatic drain();
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic write_types(logic [5:0] value);
        drain();
        i_cfg_we = 1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 0;
        pr_types = value;
    endtask

    function automatic logic [4:0] pick_type(int n);
        if ($urandom_range(9) == 0) return 5'($urandom);
        return 5'($urandom_range(n - 1));
    endfunction

    // Clear, then a random mix of loads with mostly small costs, queries, unused codes and clears
    task automatic random_phase(int n, int items);
        int sent;
        sent = 0;
        send_request(mccp_pkg::FN_CLEAR, 5'd0, 5'd0, 16'd0);
        while (sent < items) begin
            int r;
            r = $urandom_range(99);
            if (r < 55)
                send_request(mccp_pkg::FN_LOAD, pick_type(n), pick_type(n),
                             16'(($urandom_range(3) == 0) ? $urandom
                                                           : $urandom_range(20)));
            else if (r < 92)
                send_request(mccp_pkg::FN_FIND, pick_type(n), pick_type(n),
                             16'($urandom));
            else if (r < 96)
                send_request(FN_UNUSED, 5'($urandom), 5'($urandom), 16'($urandom));
            else
                send_request(mccp_pkg::FN_CLEAR, 5'($urandom), 5'($urandom),
                             16'($urandom));
            sent++;
        end
    endtask

    // Result side: stall at random, and sometimes for a long stretch
    always @(negedge i_clk)
        i_ready <= !hold_off && ($urandom_range(99) >= idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result('{o_status, o_edge_id, o_from_type, o_to_type, o_last});
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        board = new();
        pr_count = 0;
        pr_types = 6'd32;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: status cases, a chain of edges with tied path costs, extremes
        send_request(mccp_pkg::FN_FIND, 5'd5, 5'd5, 16'd0);
        send_request(mccp_pkg::FN_FIND, 5'd0, 5'd31, 16'd0);
        send_request(mccp_pkg::FN_LOAD, 5'd0, 5'd1, 16'hFFFF);
        send_request(mccp_pkg::FN_LOAD, 5'd0, 5'd2, 16'd1);
        send_request(mccp_pkg::FN_LOAD, 5'd2, 5'd1, 16'hFFFE);
        send_request(mccp_pkg::FN_LOAD, 5'd1, 5'd31, 16'd0);
        send_request(mccp_pkg::FN_LOAD, 5'd0, 5'd1, 16'hFFFF);
        send_request(mccp_pkg::FN_LOAD, 5'd31, 5'd0, 16'd7);
        send_request(mccp_pkg::FN_FIND, 5'd0, 5'd31, 16'hFFFF);
        send_request(mccp_pkg::FN_FIND, 5'd31, 5'd2, 16'd0);
        send_request(mccp_pkg::FN_FIND, 5'd3, 5'd0, 16'd0);
        send_request(FN_UNUSED, 5'd31, 5'd31, 16'hFFFF);
        write_types(6'd0);
        send_request(mccp_pkg::FN_FIND, 5'd0, 5'd0, 16'd0);
        send_request(mccp_pkg::FN_FIND, 5'd0, 5'd1, 16'd0);
        write_types(6'd63);
        send_request(mccp_pkg::FN_FIND, 5'd2, 5'd31, 16'd0);
        write_types(6'd2);
        send_request(mccp_pkg::FN_FIND, 5'd0, 5'd1, 16'd0);
        send_request(mccp_pkg::FN_FIND, 5'd0, 5'd2, 16'd0);
        send_request(mccp_pkg::FN_CLEAR, 5'd0, 5'd0, 16'd0);
        send_request(mccp_pkg::FN_FIND, 5'd0, 5'd1, 16'd0);

        // Long result hold-off while requests keep coming
        write_types(6'd32);
        fork
            begin
                hold_off = 1;
                repeat (400) @(negedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 31; i++)
                send_request(mccp_pkg::FN_LOAD, 5'(i), 5'(i + 1), 16'd1);
        join
        fork
            begin
                hold_off = 1;
                repeat (600) @(negedge i_clk);
                hold_off = 0;
            end
            repeat (4) send_request(mccp_pkg::FN_FIND, 5'd0, 5'd31, 16'd0);
        join

        // Random phases over several type counts, one with no idling
        write_types(6'd8);
        random_phase(8, 40);
        idle_pct = 0;
        write_types(6'd4);
        random_phase(4, 30);
        idle_pct = 22;
        write_types(6'd1);
        random_phase(2, 10);
        write_types(6'd32);
        random_phase(32, 35);
        write_types(6'd16);
        random_phase(16, 35);

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
